// ----- hdl/eia_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package eia_pkg;

    // Default sizing of the entity table.
    localparam int ENTITY_SLOTS_DEF = 1024;
    localparam int MASK_BITS_DEF    = 32;

    // Fixed widths of the request and response fields.
    localparam int OPCODE_W = 3;
    localparam int ENTITY_W = 10;
    localparam int MASK_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;

    // Request operations; codes five to seven are unused.
    typedef enum logic [OPCODE_W-1:0] {
        OP_ALLOC    = 3'd0,
        OP_REMOVE   = 3'd1,
        OP_EXISTS   = 3'd2,
        OP_SET_MASK = 3'd3,
        OP_GET_MASK = 3'd4
    } opcode_t;

    // Response status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_BAD_ID = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

endpackage : eia_pkg

`default_nettype wire

// ----- hdl/eia_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Request channel: one beat carries one operation.
interface eia_req_if;
    logic                          valid;
    logic                          ready;
    logic [eia_pkg::OPCODE_W-1:0]  opcode;
    logic [eia_pkg::ENTITY_W-1:0]  entity_index;
    logic [eia_pkg::MASK_W-1:0]    mask_in;

    modport source (output valid, output opcode, output entity_index, output mask_in,
                    input ready);
    modport sink   (input valid, input opcode, input entity_index, input mask_in,
                    output ready);
endinterface : eia_req_if

// Response channel: one beat carries the result of one operation.
interface eia_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [eia_pkg::STATUS_W-1:0]  status;
    logic [eia_pkg::ENTITY_W-1:0]  entity_out;
    logic [eia_pkg::MASK_W-1:0]    mask_out;
    logic                          is_live;
    logic [eia_pkg::COUNT_W-1:0]   live_count;

    modport source (output valid, output status, output entity_out, output mask_out,
                    output is_live, output live_count, input ready);
    modport sink   (input valid, input status, input entity_out, input mask_out,
                    input is_live, input live_count, output ready);
endinterface : eia_rsp_if

`default_nettype wire

// ----- hdl/entity_id_allocator_with_masks.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Entity ID allocator with per-entity component masks. Each request beat on
// req carries an opcode (allocate, remove, exists, set mask, get mask) and
// produces exactly one response beat on rsp, in order. Freed IDs are handed
// out again first, oldest first, before fresh IDs are taken. A request first
// gets the synchronous read of the entry table and of the recycle queue
// head; then it is decided, written back and loaded into the response
// register, a step that waits while a previous response waits to be
// taken. A new request is accepted while a finished response still waits.
// The live bits sit in the entry table beside the masks and need no clearing
// pass after reset: an entry counts as live only if its ID lies below the
// fresh-ID counter, and every such entry has been written by an allocate.
module entity_id_allocator_with_masks #(
    parameter int ENTITY_SLOTS = eia_pkg::ENTITY_SLOTS_DEF,
    parameter int MASK_BITS    = eia_pkg::MASK_BITS_DEF
) (
    input  wire           clk,
    input  wire           rst_n,
    eia_req_if.sink       req,
    eia_rsp_if.source     rsp
);
    import eia_pkg::*;

    localparam int ID_W  = $clog2(ENTITY_SLOTS);
    localparam int CNT_W = $clog2(ENTITY_SLOTS + 1);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    // Control state.
    state_t                 state_reg, state_next;
    logic [ID_W-1:0]        head_reg, head_next;
    logic [ID_W-1:0]        tail_reg, tail_next;
    logic [CNT_W-1:0]       fill_reg, fill_next;
    logic [CNT_W-1:0]       fresh_reg, fresh_next;
    logic [CNT_W-1:0]       live_reg, live_next;

    // Response register.
    logic                   rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0]    rsp_status_reg, rsp_status_next;
    logic [ENTITY_W-1:0]    rsp_entity_reg, rsp_entity_next;
    logic [MASK_W-1:0]      rsp_mask_reg, rsp_mask_next;
    logic                   rsp_live_reg, rsp_live_next;
    logic [COUNT_W-1:0]     rsp_count_reg, rsp_count_next;

    // Captured request.
    logic [OPCODE_W-1:0]    op_reg;
    logic [ENTITY_W-1:0]    id_reg;
    logic [MASK_W-1:0]      mask_reg;

    // Entry table holds {live, mask}; recycle queue holds freed IDs.
    logic [MASK_BITS:0]     entry_mem [ENTITY_SLOTS];
    logic [ID_W-1:0]        fifo_mem  [ENTITY_SLOTS];
    logic [MASK_BITS:0]     entry_rd_reg;
    logic [ID_W-1:0]        fifo_rd_reg;

    logic                   entry_we;
    logic [ID_W-1:0]        entry_waddr;
    logic [MASK_BITS:0]     entry_wdata;
    logic                   fifo_we;

    logic                   accept;
    logic                   fire;
    logic                   in_range;
    logic                   alive;
    logic [ID_W-1:0]        id_addr;
    logic [ID_W-1:0]        new_id;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign fire      = (state_reg == S_EXEC) && (!rsp_valid_reg || rsp.ready);

    assign id_addr  = ID_W'(id_reg);
    assign in_range = 32'(id_reg) < 32'(ENTITY_SLOTS);
    assign alive    = in_range && (32'(id_reg) < 32'(fresh_reg)) && entry_rd_reg[MASK_BITS];

    // Memory reads are issued with the request beat, data is ready next cycle.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            entry_rd_reg <= entry_mem[ID_W'(req.entity_index)];
            fifo_rd_reg  <= fifo_mem[head_reg];
            op_reg       <= req.opcode;
            id_reg       <= req.entity_index;
            mask_reg     <= req.mask_in;
        end
    end

    // Write-back into both memories.
    always_ff @(posedge clk)
    begin
        if (entry_we)
        begin
            entry_mem[entry_waddr] <= entry_wdata;
        end
        if (fifo_we)
        begin
            fifo_mem[tail_reg] <= id_addr;
        end
    end

    // Decide the operation and the next state.
    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        fill_next       = fill_reg;
        fresh_next      = fresh_reg;
        live_next       = live_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_status_next = rsp_status_reg;
        rsp_entity_next = rsp_entity_reg;
        rsp_mask_next   = rsp_mask_reg;
        rsp_live_next   = rsp_live_reg;
        rsp_count_next  = rsp_count_reg;
        entry_we        = 1'b0;
        entry_waddr     = id_addr;
        entry_wdata     = {1'b1, MASK_BITS'(mask_reg)};
        fifo_we         = 1'b0;
        new_id          = ID_W'(fresh_reg);

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        if (accept)
        begin
            state_next = S_EXEC;
        end

        if (fire)
        begin
            state_next      = S_IDLE;
            rsp_valid_next  = 1'b1;
            rsp_status_next = ST_OK;
            rsp_entity_next = id_reg;
            rsp_mask_next   = '0;
            rsp_live_next   = 1'b0;

            case (opcode_t'(op_reg))
                OP_ALLOC:
                begin
                    if (fill_reg != '0)
                    begin
                        new_id    = fifo_rd_reg;
                        head_next = (head_reg == ID_W'(ENTITY_SLOTS - 1)) ? '0
                                                                          : head_reg + 1'b1;
                        fill_next = fill_reg - 1'b1;
                    end
                    else if (32'(fresh_reg) < 32'(ENTITY_SLOTS))
                    begin
                        fresh_next = fresh_reg + 1'b1;
                    end
                    else
                    begin
                        rsp_status_next = ST_FULL;
                    end

                    if (rsp_status_next == ST_FULL)
                    begin
                        rsp_entity_next = '0;
                    end
                    else
                    begin
                        // A handed-out ID is always a dead slot, so the count grows.
                        entry_we        = 1'b1;
                        entry_waddr     = new_id;
                        entry_wdata     = {1'b1, {MASK_BITS{1'b0}}};
                        live_next       = live_reg + 1'b1;
                        rsp_entity_next = ENTITY_W'(new_id);
                    end
                end
                OP_REMOVE:
                begin
                    if (!alive)
                    begin
                        rsp_status_next = ST_BAD_ID;
                    end
                    else
                    begin
                        entry_we    = 1'b1;
                        entry_wdata = {1'b0, entry_rd_reg[MASK_BITS-1:0]};
                        fifo_we     = 1'b1;
                        tail_next   = (tail_reg == ID_W'(ENTITY_SLOTS - 1)) ? '0
                                                                            : tail_reg + 1'b1;
                        fill_next   = fill_reg + 1'b1;
                        live_next   = live_reg - 1'b1;
                    end
                end
                OP_EXISTS:
                begin
                    rsp_live_next = alive;
                end
                OP_SET_MASK:
                begin
                    if (!alive)
                    begin
                        rsp_status_next = ST_BAD_ID;
                    end
                    else
                    begin
                        entry_we = 1'b1;
                    end
                end
                OP_GET_MASK:
                begin
                    if (!alive)
                    begin
                        rsp_status_next = ST_BAD_ID;
                    end
                    else
                    begin
                        rsp_mask_next = MASK_W'(entry_rd_reg[MASK_BITS-1:0]);
                    end
                end
                default:
                begin
                    rsp_status_next = ST_BAD_ID;
                end
            endcase

            rsp_count_next = COUNT_W'(live_next);
        end
    end

    // State and response register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            tail_reg       <= '0;
            fill_reg       <= '0;
            fresh_reg      <= '0;
            live_reg       <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_status_reg <= ST_OK;
            rsp_entity_reg <= '0;
            rsp_mask_reg   <= '0;
            rsp_live_reg   <= 1'b0;
            rsp_count_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            fill_reg       <= fill_next;
            fresh_reg      <= fresh_next;
            live_reg       <= live_next;
            rsp_valid_reg  <= rsp_valid_next;
            rsp_status_reg <= rsp_status_next;
            rsp_entity_reg <= rsp_entity_next;
            rsp_mask_reg   <= rsp_mask_next;
            rsp_live_reg   <= rsp_live_next;
            rsp_count_reg  <= rsp_count_next;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.status     = rsp_status_reg;
    assign rsp.entity_out = rsp_entity_reg;
    assign rsp.mask_out   = rsp_mask_reg;
    assign rsp.is_live    = rsp_live_reg;
    assign rsp.live_count = rsp_count_reg;

`ifndef SYNTHESIS
    // Every fresh ID handed out so far is either live or waiting in the queue.
    a_id_conservation: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg + live_reg) == fresh_reg)
        else $error("live count and queue fill do not add up to fresh IDs");

    // A full status is only possible with an empty queue and no fresh ID left.
    a_full_only_when_exhausted: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_status_reg == ST_FULL) |->
            (fill_reg == '0 && 32'(fresh_reg) == 32'(ENTITY_SLOTS)))
        else $error("full status reported while IDs remain");

    // A new response beat is loaded only by the execute cycle.
    a_rsp_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_EXEC))
        else $error("response appeared without an executed request");

    // Queue pointers stay inside the table.
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(head_reg) < 32'(ENTITY_SLOTS)) && (32'(tail_reg) < 32'(ENTITY_SLOTS)))
        else $error("recycle queue pointer out of range");

    // No request is taken while the previous one is still executing.
    a_no_accept_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && !fire) |=> (state_reg == S_EXEC))
        else $error("execute cycle left before its response was loaded");
`endif

endmodule : entity_id_allocator_with_masks

`default_nettype wire
